>>> hw/rtl/swmt_pkg.sv
package swmt_pkg;

    localparam int WINDOW_SIZE = 11;
    localparam int TS_W        = 32;
    localparam int FILL_OUT_W  = 4;
    localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);
    localparam int AGE_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int IDX_W       = AGE_W;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic [TS_W-1:0]  value;
        logic [AGE_W-1:0] age;
        logic             valid;
        logic             le;    // valid and value <= incoming timestamp
        logic             dp;    // removed entry sits here or further left
    } cell_link_t;

    typedef struct packed {
        logic load;
        logic full;
    } cell_ctrl_t;

    localparam cell_link_t LINK_LEFT_EDGE = '{
        value: '0, age: '0, valid: 1'b1, le: 1'b1, dp: 1'b0
    };

    localparam cell_link_t LINK_RIGHT_EDGE = '{
        value: '0, age: '0, valid: 1'b0, le: 1'b0, dp: 1'b0
    };

endpackage

>>> hw/rtl/swmt_if.sv
interface swmt_in_if;
    import swmt_pkg::*;

    logic            valid;
    logic            ready;
    logic [TS_W-1:0] new_timestamp;

    modport source (output valid, output new_timestamp, input ready);
    modport sink   (input valid, input new_timestamp, output ready);
endinterface

interface swmt_out_if;
    import swmt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TS_W-1:0]       median_time;
    logic [FILL_OUT_W-1:0] window_fill;

    modport source (output valid, output median_time, output window_fill, input ready);
    modport sink   (input valid, input median_time, input window_fill, output ready);
endinterface

>>> hw/rtl/sliding_window_median_time.sv
// Running median over the newest WINDOW_SIZE timestamps (median time past).
// Takes one timestamp per cycle while stamp.ready is high and returns one result
// per timestamp: the entry at rank fill/2 of the window in ascending order (upper
// median for an even fill) and the current fill. The window is a row of sorted
// cells; in the cycle of a transfer the row drops the oldest entry if the window
// is full and places the new one, each cell comparing against its neighbors; the
// ripple across the row limits the clock rate. A result waits in the pending stage
// and moves into the output register once that register is free; a waiting result
// does not stop the next transfer unless a second one is already pending.
module sliding_window_median_time
    import swmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    swmt_in_if.sink           stamp,
    swmt_out_if.source        result
);

    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [TS_W-1:0]       median_reg, median_next;
    logic [FILL_OUT_W-1:0] wfill_reg, wfill_next;

    logic                  accept;
    logic                  out_free;
    logic                  capture;
    logic                  full;
    cell_ctrl_t            ctrl;
    cell_link_t            lnk [WINDOW_SIZE+2];
    logic [TS_W-1:0]       cell_val [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] cell_valid;
    logic [FILL_W-1:0]     sel;
    logic [FILL_W+FILL_OUT_W-1:0] fill_ext;

    assign full     = (fill_reg == FILL_W'(WINDOW_SIZE));
    assign out_free = !out_valid_reg || result.ready;
    assign capture  = pend_reg && out_free;
    assign stamp.ready = !pend_reg || out_free;
    assign accept   = stamp.valid && stamp.ready;

    assign ctrl.load = accept;
    assign ctrl.full = full;

    assign lnk[0]             = LINK_LEFT_EDGE;
    assign lnk[WINDOW_SIZE+1] = LINK_RIGHT_EDGE;

    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_cell
        swmt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_timestamp (stamp.new_timestamp),
            .left          (lnk[i]),
            .right         (lnk[i+2]),
            .link          (lnk[i+1])
        );
        assign cell_val[i]   = lnk[i+1].value;
        assign cell_valid[i] = lnk[i+1].valid;
    end

    assign sel      = fill_reg >> 1;
    assign fill_ext = {{FILL_OUT_W{1'b0}}, fill_reg};

    always_comb
    begin
        fill_next      = fill_reg;
        pend_next      = accept || (pend_reg && !out_free);
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        wfill_next     = wfill_reg;
        if (accept && !full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        if (capture)
        begin
            out_valid_next = 1'b1;
            median_next    = cell_val[sel[IDX_W-1:0]];
            wfill_next     = fill_ext[FILL_OUT_W-1:0];
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
        wfill_reg  <= wfill_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.median_time = median_reg;
    assign result.window_fill = wfill_reg;

`ifndef SYNTH
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(fill_reg))
        else $error("occupied cells disagree with fill count");

    a_remove_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full |-> lnk[WINDOW_SIZE].dp)
        else $error("full window transfer found no oldest entry");

    a_no_remove_filling: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> !lnk[WINDOW_SIZE].dp)
        else $error("entry removed while window is filling");

    a_pending_captured: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> result.valid)
        else $error("pending result not presented");
`endif

endmodule

>>> hw/rtl/swmt_cell.sv
module swmt_cell
    import swmt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cell_ctrl_t      ctrl,
    input  logic [TS_W-1:0] new_timestamp,
    input  cell_link_t      left,
    input  cell_link_t      right,
    output cell_link_t      link
);

    logic [TS_W-1:0]  value_reg, value_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             valid_reg, valid_next;

    logic       le;
    logic       rm;
    logic       dp;
    logic       lt_self;
    logic       lt_left;
    cell_link_t self_link;
    cell_link_t src;

    assign le = valid_reg && (value_reg <= new_timestamp);
    assign rm = ctrl.full && valid_reg && (age_reg == AGE_W'(WINDOW_SIZE - 1));
    assign dp = left.dp | rm;

    always_comb
    begin
        self_link.value = value_reg;
        self_link.age   = age_reg;
        self_link.valid = valid_reg;
        self_link.le    = le;
        self_link.dp    = dp;
    end

    assign link = self_link;

    // Kept entry at this slot stays below the new one / kept entry one slot left does.
    assign lt_self = dp ? right.le : le;
    assign lt_left = left.dp ? le : left.le;

    always_comb
    begin
        src        = self_link;
        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            valid_next = valid_reg | left.valid;
            if (lt_self)
            begin
                src        = dp ? right : self_link;
                value_next = src.value;
                age_next   = src.age + AGE_W'(1);
            end
            else if (lt_left)
            begin
                value_next = new_timestamp;
                age_next   = '0;
            end
            else
            begin
                src        = left.dp ? self_link : left;
                value_next = src.value;
                age_next   = src.age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

>>> bench/testbench.sv
module testbench;
    import swmt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 217;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [TS_W-1:0]       ts;
        logic                  typed;
        logic [TS_W-1:0]       median;
        logic [FILL_OUT_W-1:0] fill;
    } stamp_row_t;

    typedef struct {
        logic [TS_W-1:0]       median;
        logic [FILL_OUT_W-1:0] fill;
    } median_result_t;

    localparam int DIRECTED_ROWS = 22;
    localparam stamp_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'd1},
        '{32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 4'd2},
        '{32'h0000_0000, 1'b0, '0, '0},
        '{32'h8000_0000, 1'b0, '0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0, '0},
        '{32'h0000_0005, 1'b0, '0, '0},
        '{32'h0000_0005, 1'b0, '0, '0},
        '{32'h0000_0005, 1'b0, '0, '0},
        '{32'h0000_0001, 1'b0, '0, '0},
        '{32'hFFFF_FFFE, 1'b0, '0, '0},
        '{32'h0000_0064, 1'b0, '0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0, '0},
        '{32'h5555_5555, 1'b0, '0, '0},
        '{32'h0000_0000, 1'b0, '0, '0},
        '{32'h0000_0000, 1'b0, '0, '0},
        '{32'h0000_0000, 1'b0, '0, '0},
        '{32'h0000_0000, 1'b0, '0, '0},
        '{32'h0000_0000, 1'b0, '0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0, '0}
    };

    logic clk;
    logic rst_n;

    swmt_in_if  stamp_if ();
    swmt_out_if result_if ();

    sliding_window_median_time u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (stamp_if),
        .result (result_if)
    );

    // window model
    logic [TS_W-1:0] window_ts [WINDOW_SIZE];
    int unsigned     window_count;
    int unsigned     window_oldest;

    median_result_t pending_medians [$];
    int             mismatches;
    int             cycles;
    int             send_idle_pct;
    int             recv_idle_pct;
    logic [TS_W-1:0] chain_time;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [TS_W-1:0] got,
                                   input logic [TS_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic advance_window(input logic [TS_W-1:0] ts, output median_result_t res);
        logic [TS_W-1:0] sorted [WINDOW_SIZE];
        logic [TS_W-1:0] x;
        int unsigned     j;
        if (window_count < WINDOW_SIZE)
        begin
            window_ts[(window_oldest + window_count) % WINDOW_SIZE] = ts;
            window_count++;
        end
        else
        begin
            window_ts[window_oldest] = ts;
            window_oldest = (window_oldest + 1) % WINDOW_SIZE;
        end
        for (int unsigned i = 0; i < window_count; i++)
        begin
            x = window_ts[(window_oldest + i) % WINDOW_SIZE];
            j = i;
            while (j > 0 && sorted[j - 1] > x)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = x;
        end
        res.median = sorted[window_count / 2];
        res.fill = window_count[FILL_OUT_W-1:0];
    endtask

    task automatic send_stamp(input logic [TS_W-1:0] ts, input logic typed,
                              input logic [TS_W-1:0] typed_median,
                              input logic [FILL_OUT_W-1:0] typed_fill);
        median_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            stamp_if.valid <= 1'b0;
            @(posedge clk);
        end
        stamp_if.valid <= 1'b1;
        stamp_if.new_timestamp <= ts;
        do
            @(posedge clk);
        while (!stamp_if.ready);
        advance_window(ts, res);
        if (typed)
        begin
            res.median = typed_median;
            res.fill = typed_fill;
        end
        pending_medians.push_back(res);
    endtask

    function automatic logic [TS_W-1:0] next_block_time();
        logic [TS_W-1:0] ts;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
            begin
                chain_time = chain_time + $urandom_range(1200);
                ts = chain_time;
            end
            5, 6:    ts = $urandom;
            7:       ts = chain_time + $urandom_range(3);
            8:       ts = chain_time - $urandom_range(7200);
            default: ts = $urandom_range(1) ? '1 : '0;
        endcase
        return ts;
    endfunction

    task automatic wait_for_drain();
        stamp_if.valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sliding_window_median_time verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        median_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_medians.size() == 0)
                report_mismatch("unexpected transfer, median_time", result_if.median_time, '0);
            else
            begin
                want = pending_medians.pop_front();
                if (result_if.median_time !== want.median)
                    report_mismatch("median_time", result_if.median_time, want.median);
                if (result_if.window_fill !== want.fill)
                    report_mismatch("window_fill", {28'd0, result_if.window_fill},
                                    {28'd0, want.fill});
            end
        end
        result_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        rst_n = 1'b0;
        stamp_if.valid = 1'b0;
        stamp_if.new_timestamp = '0;
        result_if.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        window_count = 0;
        window_oldest = 0;
        chain_time = 32'h5F00_0000;
        for (int i = 0; i < WINDOW_SIZE; i++)
            window_ts[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_stamp(DIRECTED[i].ts, DIRECTED[i].typed, DIRECTED[i].median,
                       DIRECTED[i].fill);

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_for_drain();
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 38 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_stamp(next_block_time(), 1'b0, '0, '0);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("sliding_window_median_time verification clean");
        else
            $display("sliding_window_median_time verification failed");
        $finish;
    end

endmodule
